// ===== rtl/core/acft_pkg.sv =====
// Shared definitions for the affine coefficient solver: result widths,
// saturation limits, register indexes and the divider sideband type.
// No dependencies.
package acft_pkg;

    parameter int COORD_BITS_DEF = 12;
    parameter int FRAC_BITS_DEF  = 16;

    // Result words and the quotient that feeds the final rounding.
    parameter int OUT_BITS = 32;
    parameter int QUO_BITS = OUT_BITS + 1;

    // Six coefficients per beat: x row then y row, each (gain x, gain y, offset).
    parameter int LANES = 6;

    parameter int NUM_SRC_REGS = 6;
    parameter int REG_IDX_BITS = 3;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_SRC_X0 = 3'd0,
        REG_SRC_Y0 = 3'd1,
        REG_SRC_X1 = 3'd2,
        REG_SRC_Y1 = 3'd3,
        REG_SRC_X2 = 3'd4,
        REG_SRC_Y2 = 3'd5
    } acft_reg_t;

    // Magnitude limits, held in quotient-wide words.
    parameter logic [QUO_BITS-1:0] MAG_SAT       = {1'b1, {OUT_BITS{1'b0}}};
    parameter logic [QUO_BITS-1:0] MAG_NEG_LIMIT = {2'b01, {(OUT_BITS-1){1'b0}}};
    parameter logic [QUO_BITS-1:0] MAG_POS_LIMIT = {2'b00, {(OUT_BITS-1){1'b1}}};

    parameter logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};
    parameter logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};

    typedef struct packed {
        logic [LANES-1:0] neg;
        logic             deg;
    } acft_side_t;

endpackage

// ===== rtl/core/acft_divider.sv =====
// Pipelined restoring divider for six numerators over one shared denominator,
// one quotient bit per stage, with overflow detection at entry.
// Depends on acft_pkg.
module acft_divider #(
    parameter int NUM_BITS  = 39,
    parameter int DEN_BITS  = 26,
    parameter int SHIFT     = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [NUM_BITS-1:0]      in_num [acft_pkg::LANES],
    input  logic [DEN_BITS-1:0]      in_den,
    input  acft_pkg::acft_side_t     in_side,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [acft_pkg::QUO_BITS-1:0] out_quo [acft_pkg::LANES],
    output logic [acft_pkg::LANES-1:0]    out_sat,
    output acft_pkg::acft_side_t     out_side
);
    import acft_pkg::*;

    localparam int NST  = QUO_BITS + 1;
    localparam int CMPW = (NUM_BITS > DEN_BITS + SHIFT) ? NUM_BITS : DEN_BITS + SHIFT;

    logic                valid_reg [NST];
    logic [NST:0]        stage_rdy;
    logic [DEN_BITS-1:0] rem_reg  [NST][LANES];
    logic [QUO_BITS-1:0] low_reg  [NST][LANES];
    logic [QUO_BITS-1:0] quo_reg  [NST][LANES];
    logic [LANES-1:0]    sat_reg  [NST];
    logic [DEN_BITS-1:0] den_reg  [NST];
    acft_side_t          side_reg [NST];

    assign stage_rdy[NST] = out_ready;
    assign in_ready       = stage_rdy[0];

    generate
        for (genvar k = 0; k < NST; k++) begin : g_stage
            // A stage moves when it is empty or the one after it moves.
            assign stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];

            if (k == 0) begin : g_entry
                logic [DEN_BITS-1:0] rem_next [LANES];
                logic [QUO_BITS-1:0] low_next [LANES];
                logic [LANES-1:0]    sat_next;

                // A quotient of 2^QUO_BITS or more saturates; otherwise the
                // high numerator bits are already below the denominator.
                always_comb begin
                    logic [CMPW-1:0]             num_ext;
                    logic [CMPW-1:0]             lim_ext;
                    logic [NUM_BITS+FRAC_BITS:0] scaled;
                    lim_ext = CMPW'({in_den, {SHIFT{1'b0}}});
                    for (int l = 0; l < LANES; l++) begin
                        num_ext     = CMPW'(in_num[l]);
                        scaled      = {in_num[l], {(FRAC_BITS+1){1'b0}}};
                        sat_next[l] = (num_ext >= lim_ext);
                        rem_next[l] = sat_next[l] ? '0 : DEN_BITS'(in_num[l] >> SHIFT);
                        low_next[l] = scaled[QUO_BITS-1:0];
                    end
                end

                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        valid_reg[k] <= 1'b0;
                    end else if (stage_rdy[k]) begin
                        valid_reg[k] <= in_valid;
                    end
                end

                always_ff @(posedge aclk) begin
                    if (stage_rdy[k]) begin
                        rem_reg[k]  <= rem_next;
                        low_reg[k]  <= low_next;
                        quo_reg[k]  <= '{default: '0};
                        sat_reg[k]  <= sat_next;
                        den_reg[k]  <= in_den;
                        side_reg[k] <= in_side;
                    end
                end
            end else begin : g_bit
                logic [DEN_BITS-1:0] rem_next [LANES];
                logic [QUO_BITS-1:0] low_next [LANES];
                logic [QUO_BITS-1:0] quo_next [LANES];

                always_comb begin
                    logic [DEN_BITS:0] trial;
                    logic              ge;
                    for (int l = 0; l < LANES; l++) begin
                        trial = {rem_reg[k-1][l], low_reg[k-1][l][QUO_BITS-1]};
                        ge    = (trial >= {1'b0, den_reg[k-1]});
                        if (ge) begin
                            trial = trial - {1'b0, den_reg[k-1]};
                        end
                        rem_next[l] = trial[DEN_BITS-1:0];
                        low_next[l] = {low_reg[k-1][l][QUO_BITS-2:0], 1'b0};
                        quo_next[l] = {quo_reg[k-1][l][QUO_BITS-2:0], ge};
                    end
                end

                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        valid_reg[k] <= 1'b0;
                    end else if (stage_rdy[k]) begin
                        valid_reg[k] <= valid_reg[k-1];
                    end
                end

                always_ff @(posedge aclk) begin
                    if (stage_rdy[k]) begin
                        rem_reg[k]  <= rem_next;
                        low_reg[k]  <= low_next;
                        quo_reg[k]  <= quo_next;
                        sat_reg[k]  <= sat_reg[k-1];
                        den_reg[k]  <= den_reg[k-1];
                        side_reg[k] <= side_reg[k-1];
                    end
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NST-1];
    assign out_quo   = quo_reg[NST-1];
    assign out_sat   = sat_reg[NST-1];
    assign out_side  = side_reg[NST-1];

    // The partial remainder must stay below the divisor in every live lane.
    logic entry_ok;
    logic last_ok;

    always_comb begin
        entry_ok = 1'b1;
        last_ok  = 1'b1;
        for (int l = 0; l < LANES; l++) begin
            if (!sat_reg[0][l] && !side_reg[0].deg && !(rem_reg[0][l] < den_reg[0])) begin
                entry_ok = 1'b0;
            end
            if (!sat_reg[NST-1][l] && !side_reg[NST-1].deg &&
                !(rem_reg[NST-1][l] < den_reg[NST-1])) begin
                last_ok = 1'b0;
            end
        end
    end

    a_entry_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[0] |-> entry_ok)
        else $error("divider entry remainder not below divisor");

    a_last_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[NST-1] |-> last_ok)
        else $error("divider final remainder not below divisor");

    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> valid_reg[0])
        else $error("divider dropped an accepted beat");

endmodule

// ===== rtl/core/affine_coeff_from_three_points_core.sv =====
// Affine coefficient solver: from three source points held in registers and
// three destination points per beat, computes the six Q15.16 coefficients.
// Depends on acft_pkg and acft_divider.
//
// Usage: write the six source coordinates (index 0..5: x0,y0,x1,y1,x2,y2)
// while the block is idle, then stream destination point sets. One beat is
// accepted per clock while the output side does not stall, and every beat
// yields exactly one result beat. Front stages build the adjugate, determinant
// and numerators, then the shared 34-stage restoring divider produces one
// quotient bit per stage after entry for all six coefficients, and a final
// stage rounds to nearest (ties away from zero) and saturates. Each stage
// takes a new beat whenever it is empty or its successor moves, so bubbles
// close up and input is still taken while a result waits at the output.
// Collinear source points give degenerate = 1 with all coefficients zero.
module affine_coeff_from_three_points_core #(
    parameter int COORD_BITS = acft_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = acft_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [acft_pkg::REG_IDX_BITS-1:0]    cfg_index,
    input  logic [COORD_BITS-1:0]                cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [COORD_BITS-1:0]                s_dst_x0,
    input  logic [COORD_BITS-1:0]                s_dst_y0,
    input  logic [COORD_BITS-1:0]                s_dst_x1,
    input  logic [COORD_BITS-1:0]                s_dst_y1,
    input  logic [COORD_BITS-1:0]                s_dst_x2,
    input  logic [COORD_BITS-1:0]                s_dst_y2,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [acft_pkg::OUT_BITS-1:0] m_coef_xx,
    output logic signed [acft_pkg::OUT_BITS-1:0] m_coef_xy,
    output logic signed [acft_pkg::OUT_BITS-1:0] m_coef_xo,
    output logic signed [acft_pkg::OUT_BITS-1:0] m_coef_yx,
    output logic signed [acft_pkg::OUT_BITS-1:0] m_coef_yy,
    output logic signed [acft_pkg::OUT_BITS-1:0] m_coef_yo,
    output logic                                 m_degenerate
);
    import acft_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int ADJW  = 2*C + 1;
    localparam int DETW  = 2*C + 3;
    localparam int DENW  = DETW - 1;
    localparam int TERMW = 3*C + 2;
    localparam int NUMW  = TERMW + 2;
    localparam int MAGW  = NUMW - 1;
    localparam int SHIFT = OUT_BITS - FRAC_BITS;

    // Source point registers.
    logic [C-1:0] src_reg [NUM_SRC_REGS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SRC_REGS; i++) begin
                src_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SRC_X0: src_reg[0] <= cfg_wdata;
                REG_SRC_Y0: src_reg[1] <= cfg_wdata;
                REG_SRC_X1: src_reg[2] <= cfg_wdata;
                REG_SRC_Y1: src_reg[3] <= cfg_wdata;
                REG_SRC_X2: src_reg[4] <= cfg_wdata;
                REG_SRC_Y2: src_reg[5] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [C-1:0] pa, pb, pc, pd, pe, pf;
    assign pa = src_reg[0];
    assign pb = src_reg[1];
    assign pc = src_reg[2];
    assign pd = src_reg[3];
    assign pe = src_reg[4];
    assign pf = src_reg[5];

    logic rdy1, rdy2, rdy3, rdy4, rdy5, div_in_ready;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    assign rdy1    = !v1_reg || rdy2;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy5    = !v5_reg || div_in_ready;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: first two adjugate rows (differences) and the cross products.
    logic signed [C:0]   diff_next  [6];
    logic [2*C-1:0]      prod_next  [6];
    logic signed [C:0]   diff1_reg  [6];
    logic [2*C-1:0]      prod1_reg  [6];
    logic [C-1:0]        dx1_reg    [3];
    logic [C-1:0]        dy1_reg    [3];

    always_comb begin
        diff_next[0] = $signed({1'b0, pd}) - $signed({1'b0, pf});
        diff_next[1] = $signed({1'b0, pf}) - $signed({1'b0, pb});
        diff_next[2] = $signed({1'b0, pb}) - $signed({1'b0, pd});
        diff_next[3] = $signed({1'b0, pe}) - $signed({1'b0, pc});
        diff_next[4] = $signed({1'b0, pa}) - $signed({1'b0, pe});
        diff_next[5] = $signed({1'b0, pc}) - $signed({1'b0, pa});
        prod_next[0] = pc * pf;
        prod_next[1] = pd * pe;
        prod_next[2] = pb * pe;
        prod_next[3] = pa * pf;
        prod_next[4] = pa * pd;
        prod_next[5] = pb * pc;
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            diff1_reg <= diff_next;
            prod1_reg <= prod_next;
            dx1_reg   <= '{s_dst_x0, s_dst_x1, s_dst_x2};
            dy1_reg   <= '{s_dst_y0, s_dst_y1, s_dst_y2};
        end
    end

    // Stage 2: third adjugate row.
    logic signed [ADJW-1:0] adj2_next [3];
    logic signed [ADJW-1:0] adj2_reg  [3];
    logic signed [C:0]      diff2_reg [6];
    logic [C-1:0]           dx2_reg   [3];
    logic [C-1:0]           dy2_reg   [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            adj2_next[j] = $signed({1'b0, prod1_reg[2*j]}) - $signed({1'b0, prod1_reg[2*j+1]});
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            adj2_reg  <= adj2_next;
            diff2_reg <= diff1_reg;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
        end
    end

    // Stage 3: determinant (sum of the third adjugate row) and the products
    // of adjugate entries with destination coordinates.
    logic signed [DETW-1:0]  det_next;
    logic signed [TERMW-1:0] term_next [LANES][3];
    logic signed [DETW-1:0]  det3_reg;
    logic signed [TERMW-1:0] term3_reg [LANES][3];

    always_comb begin
        logic [C-1:0]       coord;
        logic signed [2*C+1:0] small_prod;
        det_next = DETW'(adj2_reg[0]) + DETW'(adj2_reg[1]) + DETW'(adj2_reg[2]);
        for (int ax = 0; ax < 2; ax++) begin
            for (int row = 0; row < 3; row++) begin
                for (int j = 0; j < 3; j++) begin
                    coord = (ax == 0) ? dx2_reg[j] : dy2_reg[j];
                    small_prod = diff2_reg[(row == 2) ? j : row*3 + j]
                                 * $signed({1'b0, coord});
                    if (row == 2) begin
                        term_next[ax*3+row][j] = adj2_reg[j] * $signed({1'b0, coord});
                    end else begin
                        term_next[ax*3+row][j] = TERMW'(small_prod);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            det3_reg  <= det_next;
            term3_reg <= term_next;
        end
    end

    // Stage 4: numerators.
    logic signed [NUMW-1:0] num_next [LANES];
    logic signed [NUMW-1:0] num4_reg [LANES];
    logic signed [DETW-1:0] det4_reg;
    logic                   deg4_reg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            num_next[l] = NUMW'(term3_reg[l][0]) + NUMW'(term3_reg[l][1])
                        + NUMW'(term3_reg[l][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            num4_reg <= num_next;
            det4_reg <= det3_reg;
            deg4_reg <= (det3_reg == '0);
        end
    end

    // Stage 5: magnitudes and result signs.
    logic [MAGW-1:0]        mag_next  [LANES];
    logic [DENW-1:0]        den_next;
    acft_side_t             side_next;
    logic [MAGW-1:0]        mag5_reg  [LANES];
    logic [DENW-1:0]        den5_reg;
    acft_side_t             side5_reg;

    always_comb begin
        logic signed [NUMW-1:0] neg_num;
        logic signed [DETW-1:0] neg_det;
        neg_det  = -det4_reg;
        den_next = det4_reg[DETW-1] ? DENW'(neg_det) : DENW'(det4_reg);
        side_next.deg = deg4_reg;
        for (int l = 0; l < LANES; l++) begin
            neg_num = -num4_reg[l];
            mag_next[l] = num4_reg[l][NUMW-1] ? MAGW'(neg_num) : MAGW'(num4_reg[l]);
            side_next.neg[l] = num4_reg[l][NUMW-1] ^ det4_reg[DETW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            mag5_reg  <= mag_next;
            den5_reg  <= den_next;
            side5_reg <= side_next;
        end
    end

    // Divider.
    logic                div_out_valid;
    logic                div_out_ready;
    logic [QUO_BITS-1:0] div_quo [LANES];
    logic [LANES-1:0]    div_sat;
    acft_side_t          div_side;

    acft_divider #(
        .NUM_BITS  (MAGW),
        .DEN_BITS  (DENW),
        .SHIFT     (SHIFT),
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v5_reg),
        .in_ready  (div_in_ready),
        .in_num    (mag5_reg),
        .in_den    (den5_reg),
        .in_side   (side5_reg),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .out_quo   (div_quo),
        .out_sat   (div_sat),
        .out_side  (div_side)
    );

    // Output stage: the divider returns floor(2^(FRAC_BITS+1) * n / d), so
    // adding one and halving rounds half away from zero on the magnitude.
    logic                       m_valid_reg;
    logic signed [OUT_BITS-1:0] coef_next [LANES];
    logic signed [OUT_BITS-1:0] coef_reg  [LANES];
    logic                       deg_reg;

    assign div_out_ready = !m_valid_reg || m_ready;

    always_comb begin
        logic [QUO_BITS:0]   q_inc;
        logic [QUO_BITS-1:0] mag;
        logic [QUO_BITS-1:0] neg_mag;
        for (int l = 0; l < LANES; l++) begin
            q_inc   = {1'b0, div_quo[l]} + (QUO_BITS+1)'(1);
            mag     = div_sat[l] ? MAG_SAT : q_inc[QUO_BITS:1];
            neg_mag = -mag;
            if (div_side.deg) begin
                coef_next[l] = '0;
            end else if (div_side.neg[l]) begin
                coef_next[l] = (mag > MAG_NEG_LIMIT) ? OUT_MIN : neg_mag[OUT_BITS-1:0];
            end else begin
                coef_next[l] = (mag > MAG_POS_LIMIT) ? OUT_MAX : mag[OUT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (div_out_ready) begin
            m_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_out_ready) begin
            coef_reg <= coef_next;
            deg_reg  <= div_side.deg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_coef_xx    = coef_reg[0];
    assign m_coef_xy    = coef_reg[1];
    assign m_coef_xo    = coef_reg[2];
    assign m_coef_yx    = coef_reg[3];
    assign m_coef_yy    = coef_reg[4];
    assign m_coef_yo    = coef_reg[5];
    assign m_degenerate = deg_reg;

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> (m_coef_xx == '0) && (m_coef_xy == '0) &&
            (m_coef_xo == '0) && (m_coef_yx == '0) && (m_coef_yy == '0) &&
            (m_coef_yo == '0))
        else $error("degenerate result carries nonzero coefficients");

    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted beat did not enter the pipeline");

    a_deg_den: assert property (@(posedge aclk) disable iff (!aresetn)
        v5_reg |-> (side5_reg.deg == (den5_reg == '0)))
        else $error("degenerate flag disagrees with determinant");

endmodule
